// File: design/afcd_pkg.sv
package afcd_pkg;

  localparam int unsigned FRAME_BYTES_DEF   = 64000;
  localparam int unsigned PALETTE_BYTES_DEF = 768;
  localparam int unsigned WP_W              = 17;

  localparam logic [7:0] RUN_MARK     = 8'hC0;
  localparam logic [7:0] RUN_MASK     = 8'h3F;
  localparam logic [7:0] NUM_COMMANDS = 8'd10;

  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_RDF   = 2'd2;
  localparam logic [1:0] ACT_RDP   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_BADADDR = 3'd5;

  localparam logic [1:0] R_MORE  = 2'd0;
  localparam logic [1:0] R_DONE  = 2'd1;
  localparam logic [1:0] R_TRUNC = 2'd3;

  localparam logic [2:0] PH_IDLE = 3'd7;

  localparam logic [3:0] CMD_PAL_FILL = 4'd0;
  localparam logic [3:0] CMD_PAL_COPY = 4'd1;
  localparam logic [3:0] CMD_PAL_RLE  = 4'd2;
  localparam logic [3:0] CMD_PAL_SEG  = 4'd3;
  localparam logic [3:0] CMD_FRM_FILL = 4'd4;
  localparam logic [3:0] CMD_FRM_COPY = 4'd5;
  localparam logic [3:0] CMD_FRM_RLE  = 4'd6;
  localparam logic [3:0] CMD_PIX_SET  = 4'd7;
  localparam logic [3:0] CMD_RUN_FILL = 4'd8;
  localparam logic [3:0] CMD_FRM_SEG  = 4'd9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_READ
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic is_read;
    logic sweeps;
  } dp_stat_t;

endpackage

// File: design/afcd_ctrl.sv
module afcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  afcd_pkg::dp_stat_t stat_i,
  output afcd_pkg::dp_cmd_t  cmd_o
);
  import afcd_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
    cmd_o.accept  = in_valid_i && in_ready_o;
    cmd_o.capture = (state_q == S_READ);
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) begin
          if (stat_i.is_read) begin
            state_d = S_READ;
          end else begin
            out_valid_d = 1'b1;
            if (stat_i.sweeps) state_d = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (!stat_i.busy) state_d = S_IDLE;
      end
      S_READ: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/afcd_dp.sv
module afcd_dp #(
  parameter int unsigned FRAME_BYTES   = afcd_pkg::FRAME_BYTES_DEF,
  parameter int unsigned PALETTE_BYTES = afcd_pkg::PALETTE_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  afcd_pkg::dp_cmd_t  cmd_i,
  output afcd_pkg::dp_stat_t stat_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         stream_byte_i,
  input  logic [15:0]        command_count_i,
  input  logic [15:0]        frame_byte_count_i,
  input  logic [15:0]        read_address_i,
  output logic [7:0]         read_value_o,
  output logic [2:0]         status_o
);
  import afcd_pkg::*;

  localparam int unsigned FI_W = $clog2(FRAME_BYTES);
  localparam int unsigned PI_W = $clog2(PALETTE_BYTES);
  localparam int unsigned SC_W = FI_W + 1;
  localparam logic [WP_W-1:0] FSIZE = WP_W'(FRAME_BYTES);
  localparam logic [WP_W-1:0] PSIZE = WP_W'(PALETTE_BYTES);

  logic [7:0] frame_mem [FRAME_BYTES];
  logic [7:0] pal_mem   [PALETTE_BYTES];

  logic [15:0]     cl_q, cl_d, bl_q, bl_d, seg_q, seg_d, sl_q, sl_d;
  logic            open_q, open_d;
  logic [3:0]      cmd_q, cmd_d;
  logic [2:0]      ph_q, ph_d;
  logic [WP_W-1:0] wp_q, wp_d;
  logic [7:0]      held_q, held_d;

  logic [FI_W-1:0] sw_addr_q, sw_addr_d;
  logic [SC_W-1:0] sw_left_q, sw_left_d;
  logic [7:0]      sw_val_q, sw_val_d;
  logic            sw_f_q, sw_f_d, sw_p_q, sw_p_d;

  logic [7:0] out_val_q, frd_q, prd_q;
  logic [2:0] out_st_q;
  logic       rsel_q, rbad_q;

  logic [2:0]      st;
  logic [1:0]      r;
  logic [15:0]     bl_n;
  logic [7:0]      b;
  logic            iw_f, iw_p, sw_go, ss;
  logic [2:0]      ss_h;
  logic [WP_W-1:0] sw_start, size, room, cnt;
  logic [17:0]     s3;
  logic [9:0]      b3;

  assign b  = stream_byte_i;
  assign b3 = {2'b00, b} + {1'b0, b, 1'b0};

  always_comb begin
    cl_d = cl_q; bl_d = bl_q; seg_d = seg_q; sl_d = sl_q; open_d = open_q;
    cmd_d = cmd_q; ph_d = ph_q; wp_d = wp_q; held_d = held_q;
    st = ST_OK; r = R_MORE; iw_f = 1'b0; iw_p = 1'b0; sw_go = 1'b0;
    sw_start = '0; cnt = '0; sw_f_d = sw_f_q; sw_p_d = sw_p_q;
    ss = 1'b0; ss_h = 3'd0; s3 = '0; room = '0;
    bl_n = bl_q - 16'd1;
    size = (cmd_q == CMD_PAL_RLE) ? PSIZE : FSIZE;
    unique case (action_i)
      ACT_BEGIN: begin
        cl_d   = command_count_i;
        bl_d   = frame_byte_count_i;
        ph_d   = PH_IDLE;
        open_d = (command_count_i != 16'd0) && (frame_byte_count_i != 16'd0);
        st     = open_d ? ST_OK : ST_DONE;
      end
      ACT_DATA: begin
        if (!open_q) begin
          st = ST_IGNORED;
        end else begin
          bl_d = bl_n;
          if (ph_q == PH_IDLE && b >= NUM_COMMANDS) begin
            open_d = 1'b0;
            st     = ST_UNKNOWN;
          end else begin
            if (ph_q == PH_IDLE) begin
              cmd_d = b[3:0]; ph_d = 3'd0; wp_d = '0; sl_d = '0; seg_d = '0; held_d = '0;
              if ((b[3:0] == CMD_PAL_COPY && {1'b0, bl_n} < PSIZE) ||
                  (b[3:0] == CMD_FRM_COPY && {1'b0, bl_n} < FSIZE) ||
                  (b[3:0] == CMD_PAL_SEG && bl_n < 16'd1) ||
                  (b[3:0] >= CMD_PIX_SET && bl_n < 16'd2)) r = R_TRUNC;
            end else begin
              unique case (cmd_q)
                CMD_PAL_FILL: begin
                  sw_go = 1'b1; sw_f_d = 1'b0; sw_p_d = 1'b1; cnt = PSIZE; r = R_DONE;
                end
                CMD_FRM_FILL: begin
                  sw_go = 1'b1; sw_f_d = 1'b1; sw_p_d = 1'b0; cnt = FSIZE; r = R_DONE;
                end
                CMD_PAL_COPY, CMD_FRM_COPY: begin
                  size = (cmd_q == CMD_PAL_COPY) ? PSIZE : FSIZE;
                  if (wp_q < size) begin
                    iw_p = (cmd_q == CMD_PAL_COPY);
                    iw_f = (cmd_q == CMD_FRM_COPY);
                  end
                  wp_d = wp_q + 1'b1;
                  r = (wp_d >= size) ? R_DONE : R_MORE;
                end
                CMD_PAL_RLE, CMD_FRM_RLE: begin
                  if (ph_q == 3'd0) begin
                    if ((b & RUN_MARK) == RUN_MARK) begin
                      sl_d = {8'd0, b & RUN_MASK};
                      ph_d = 3'd1;
                    end else begin
                      if (wp_q < size) begin
                        iw_p = (cmd_q == CMD_PAL_RLE);
                        iw_f = (cmd_q == CMD_FRM_RLE);
                      end
                      wp_d = wp_q + 1'b1;
                      r = (wp_d >= size) ? R_DONE : R_MORE;
                    end
                  end else begin
                    if (wp_q < size) begin
                      room  = size - wp_q;
                      cnt   = (WP_W'(sl_q) < room) ? WP_W'(sl_q) : room;
                      sw_go = 1'b1; sw_start = wp_q;
                      sw_p_d = (cmd_q == CMD_PAL_RLE);
                      sw_f_d = (cmd_q == CMD_FRM_RLE);
                    end
                    wp_d = wp_q + WP_W'(sl_q);
                    ph_d = 3'd0;
                    r = (wp_d >= size) ? R_DONE : R_MORE;
                  end
                end
                CMD_PAL_SEG: begin
                  unique case (ph_q)
                    3'd0: begin
                      seg_d = {8'd0, b}; ss = 1'b1; ss_h = 3'd2;
                    end
                    3'd1: begin
                      wp_d = WP_W'(b3); ph_d = 3'd2;
                    end
                    3'd2: begin
                      sl_d = {6'd0, b3};
                      if (bl_n < sl_d) r = R_TRUNC;
                      else if (sl_d == 16'd0) begin
                        seg_d = seg_q - 16'd1; ss = 1'b1; ss_h = 3'd2;
                      end else ph_d = ({1'b0, wp_q} + {8'd0, b3} <= {1'b0, PSIZE}) ? 3'd3 : 3'd4;
                    end
                    default: begin
                      if (ph_q == 3'd3 && wp_q < PSIZE) iw_p = 1'b1;
                      wp_d = wp_q + 1'b1;
                      sl_d = sl_q - 16'd1;
                      if (sl_d == 16'd0) begin
                        seg_d = seg_q - 16'd1; ss = 1'b1; ss_h = 3'd2;
                      end
                    end
                  endcase
                end
                default: begin
                  if (ph_q == 3'd0 || ph_q == 3'd2) begin
                    held_d = b; ph_d = ph_q + 3'd1;
                  end else if (ph_q == 3'd1) begin
                    seg_d = {b, held_q};
                    if (cmd_q == CMD_PIX_SET) begin
                      s3 = {2'b00, seg_d} + {1'b0, seg_d, 1'b0};
                      if (s3 > {2'b00, bl_n}) r = R_TRUNC;
                      else if (seg_d == 16'd0) r = R_DONE;
                      else ph_d = 3'd2;
                    end else begin
                      ss = 1'b1; ss_h = (cmd_q == CMD_RUN_FILL) ? 3'd4 : 3'd3;
                    end
                  end else if (ph_q == 3'd3) begin
                    wp_d = {1'b0, b, held_q}; ph_d = 3'd4;
                  end else if (cmd_q == CMD_PIX_SET) begin
                    if (wp_q < FSIZE) iw_f = 1'b1;
                    seg_d = seg_q - 16'd1;
                    if (seg_d == 16'd0) r = R_DONE;
                    else ph_d = 3'd2;
                  end else if (cmd_q == CMD_RUN_FILL) begin
                    if (ph_q == 3'd4) begin
                      sl_d = {8'd0, b}; ph_d = 3'd5;
                    end else begin
                      if ({1'b0, wp_q} + {2'b00, sl_q} <= {1'b0, FSIZE}) begin
                        sw_go = 1'b1; sw_start = wp_q; cnt = WP_W'(sl_q);
                        sw_f_d = 1'b1; sw_p_d = 1'b0;
                      end
                      seg_d = seg_q - 16'd1; ss = 1'b1; ss_h = 3'd4;
                    end
                  end else if (ph_q == 3'd4) begin
                    sl_d = {8'd0, b};
                    if (bl_n < sl_d) r = R_TRUNC;
                    else if (sl_d == 16'd0) begin
                      seg_d = seg_q - 16'd1; ss = 1'b1; ss_h = 3'd3;
                    end else ph_d = ({1'b0, wp_q} + {10'd0, b} <= {1'b0, FSIZE}) ? 3'd5 : 3'd6;
                  end else begin
                    if (ph_q == 3'd5 && wp_q < FSIZE) iw_f = 1'b1;
                    wp_d = wp_q + 1'b1;
                    sl_d = sl_q - 16'd1;
                    if (sl_d == 16'd0) begin
                      seg_d = seg_q - 16'd1; ss = 1'b1; ss_h = 3'd3;
                    end
                  end
                end
              endcase
              if (ss) begin
                if (seg_d == 16'd0) r = R_DONE;
                else if (bl_n < {13'd0, ss_h}) r = R_TRUNC;
                else begin
                  ph_d = (cmd_q == CMD_PAL_SEG) ? 3'd1 : 3'd2;
                  r = R_MORE;
                end
              end
            end
            if (r == R_TRUNC) begin
              open_d = 1'b0; st = ST_TRUNC;
            end else begin
              if (r == R_DONE) begin
                cl_d = cl_q - 16'd1;
                ph_d = PH_IDLE;
              end
              if (r == R_DONE && cl_d == 16'd0) begin
                open_d = 1'b0; st = ST_DONE;
              end else if (bl_n == 16'd0) begin
                open_d = 1'b0; st = ST_TRUNC;
                if (ph_d != PH_IDLE && (cmd_d == CMD_PAL_RLE || cmd_d == CMD_FRM_RLE)) begin
                  ph_d = PH_IDLE;
                  cl_d = cl_d - 16'd1;
                  if (cl_d == 16'd0) st = ST_DONE;
                end
              end
            end
          end
        end
      end
      ACT_RDF: if ({1'b0, read_address_i} >= FSIZE) st = ST_BADADDR;
      ACT_RDP: if ({1'b0, read_address_i} >= PSIZE) st = ST_BADADDR;
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    sw_addr_d = sw_addr_q;
    sw_left_d = sw_left_q;
    sw_val_d  = sw_val_q;
    if (sw_left_q != '0) begin
      sw_addr_d = sw_addr_q + 1'b1;
      sw_left_d = sw_left_q - 1'b1;
    end else if (cmd_i.accept && sw_go) begin
      sw_addr_d = sw_start[FI_W-1:0];
      sw_left_d = cnt[SC_W-1:0];
      sw_val_d  = b;
    end
  end

  assign stat_o.busy    = (sw_left_q != '0);
  assign stat_o.is_read = (action_i == ACT_RDF) || (action_i == ACT_RDP);
  assign stat_o.sweeps  = sw_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_q <= '0; bl_q <= '0; seg_q <= '0; sl_q <= '0; open_q <= 1'b0;
      cmd_q <= '0; ph_q <= '0; wp_q <= '0; held_q <= '0;
      sw_addr_q <= '0; sw_left_q <= SC_W'(FRAME_BYTES); sw_val_q <= '0;
      sw_f_q <= 1'b1; sw_p_q <= 1'b1;
    end else begin
      sw_addr_q <= sw_addr_d;
      sw_left_q <= sw_left_d;
      sw_val_q  <= sw_val_d;
      if (cmd_i.accept) begin
        cl_q <= cl_d; bl_q <= bl_d; seg_q <= seg_d; sl_q <= sl_d; open_q <= open_d;
        cmd_q <= cmd_d; ph_q <= ph_d; wp_q <= wp_d; held_q <= held_d;
        if (sw_go) begin
          sw_f_q <= sw_f_d;
          sw_p_q <= sw_p_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_left_q != '0) begin
      if (sw_f_q) frame_mem[sw_addr_q] <= sw_val_q;
    end else if (cmd_i.accept && iw_f) begin
      frame_mem[wp_q[FI_W-1:0]] <= b;
    end
    if (cmd_i.accept && action_i == ACT_RDF && st == ST_OK) begin
      frd_q <= frame_mem[read_address_i[FI_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_left_q != '0) begin
      if (sw_p_q && {1'b0, sw_addr_q} < PSIZE[FI_W:0]) pal_mem[sw_addr_q[PI_W-1:0]] <= sw_val_q;
    end else if (cmd_i.accept && iw_p) begin
      pal_mem[wp_q[PI_W-1:0]] <= b;
    end
    if (cmd_i.accept && action_i == ACT_RDP && st == ST_OK) begin
      prd_q <= pal_mem[read_address_i[PI_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      out_val_q <= '0;
      out_st_q  <= st;
      rsel_q    <= (action_i == ACT_RDF);
      rbad_q    <= (st == ST_BADADDR);
    end else if (cmd_i.capture) begin
      out_val_q <= rbad_q ? 8'd0 : (rsel_q ? frd_q : prd_q);
    end
  end

  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;

endmodule

// File: design/animation_frame_command_decoder_top.sv
// channel  direction  tdata                                          tuser
// s_axis   in         [7:0] stream_byte, [23:8] command_count,        [1:0] action
//                     [39:24] frame_byte_count, [55:40] read_address
// m_axis   out        [7:0] read_value                               [2:0] status
//
// Begin and data words are answered from the output register; reads first go
// through a registered store read (S_READ). Fills sweep the whole store (PALETTE_BYTES
// or FRAME_BYTES bytes), RLE runs and run fills their run; input is held until done.
// After reset a clearing pass over FRAME_BYTES addresses zeroes both stores before
// the first word is taken. A stalled result holds in the output register.
module animation_frame_command_decoder_top #(
  parameter int unsigned FRAME_BYTES   = afcd_pkg::FRAME_BYTES_DEF,
  parameter int unsigned PALETTE_BYTES = afcd_pkg::PALETTE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // stream_byte, command_count, frame_byte_count, read_address
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // read_value
  output logic [2:0]  m_axis_tuser   // status
);
  import afcd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  afcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  afcd_dp #(
    .FRAME_BYTES   (FRAME_BYTES),
    .PALETTE_BYTES (PALETTE_BYTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .action_i           (s_axis_tuser),
    .stream_byte_i      (s_axis_tdata[7:0]),
    .command_count_i    (s_axis_tdata[23:8]),
    .frame_byte_count_i (s_axis_tdata[39:24]),
    .read_address_i     (s_axis_tdata[55:40]),
    .read_value_o       (m_axis_tdata),
    .status_o           (m_axis_tuser)
  );

endmodule

// File: dv/animation_frame_command_decoder_top_tb.sv
module animation_frame_command_decoder_top_tb;
  import afcd_pkg::*;

  localparam int unsigned FB = FRAME_BYTES_DEF;
  localparam int unsigned PB = PALETTE_BYTES_DEF;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  byte_val;
    logic [15:0] cmd_cnt;
    logic [15:0] byte_cnt;
    logic [15:0] addr;
  } word_t;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] status;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  animation_frame_command_decoder_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // decoder shadow state
  logic [7:0]  frm_mem [FB];
  logic [7:0]  pal_mem [PB];
  int unsigned cmds_left, bytes_left, segs_left, wr_pos, seg_len, low_byte;
  int unsigned cur_cmd, phase;
  bit          open;

  reply_t      reply_q[$];
  word_t       dir_words[$];
  reply_t      dir_replies[$];
  int          errors = 0;
  int          results = 0;
  int          words_sent = 0;
  int          frames = 0;
  int          fills_left = 2;
  bit          no_idle = 0;
  bit          long_req = 0;
  bit          long_done = 0;
  bit          paused = 0;

  function automatic int unsigned rle_step(bit to_frame, int unsigned b);
    int unsigned size;
    int unsigned n;
    size = to_frame ? FB : PB;
    if (phase == 0) begin
      if ((b & RUN_MARK) == RUN_MARK) begin
        seg_len = b & RUN_MASK;
        phase = 1;
        return R_MORE;
      end
      if (wr_pos < size) begin
        if (to_frame) frm_mem[wr_pos] = b[7:0];
        else pal_mem[wr_pos] = b[7:0];
      end
      wr_pos++;
    end else begin
      if (wr_pos < size) begin
        n = (seg_len < size - wr_pos) ? seg_len : size - wr_pos;
        for (int unsigned i = 0; i < n; i++) begin
          if (to_frame) frm_mem[wr_pos + i] = b[7:0];
          else pal_mem[wr_pos + i] = b[7:0];
        end
      end
      wr_pos += seg_len;
      phase = 0;
    end
    return (wr_pos >= size) ? R_DONE : R_MORE;
  endfunction

  function automatic int unsigned seg_start(int unsigned hdr);
    if (segs_left == 0) return R_DONE;
    if (bytes_left < hdr) return R_TRUNC;
    phase = (cur_cmd == CMD_PAL_SEG) ? 1 : 2;
    return R_MORE;
  endfunction

  function automatic int unsigned seg_end(int unsigned hdr);
    segs_left = (segs_left - 1) & 16'hFFFF;
    return seg_start(hdr);
  endfunction

  function automatic int unsigned take_byte(int unsigned b);
    case (cur_cmd)
      CMD_PAL_FILL: begin
        for (int i = 0; i < PB; i++) pal_mem[i] = b[7:0];
        return R_DONE;
      end
      CMD_FRM_FILL: begin
        for (int i = 0; i < FB; i++) frm_mem[i] = b[7:0];
        return R_DONE;
      end
      CMD_PAL_COPY: begin
        if (wr_pos < PB) pal_mem[wr_pos] = b[7:0];
        wr_pos++;
        return (wr_pos >= PB) ? R_DONE : R_MORE;
      end
      CMD_FRM_COPY: begin
        if (wr_pos < FB) frm_mem[wr_pos] = b[7:0];
        wr_pos++;
        return (wr_pos >= FB) ? R_DONE : R_MORE;
      end
      CMD_PAL_RLE: return rle_step(0, b);
      CMD_FRM_RLE: return rle_step(1, b);
      CMD_PAL_SEG: begin
        case (phase)
          0: begin
            segs_left = b;
            return seg_start(2);
          end
          1: begin
            wr_pos = b * 3;
            phase = 2;
            return R_MORE;
          end
          2: begin
            seg_len = b * 3;
            if (bytes_left < seg_len) return R_TRUNC;
            if (seg_len == 0) return seg_end(2);
            phase = (wr_pos + seg_len <= PB) ? 3 : 4;
            return R_MORE;
          end
          default: begin
            if (phase == 3 && wr_pos < PB) pal_mem[wr_pos] = b[7:0];
            wr_pos++;
            seg_len--;
            return (seg_len == 0) ? seg_end(2) : R_MORE;
          end
        endcase
      end
      default: begin
        if (phase == 0 || phase == 2) begin
          low_byte = b;
          phase++;
          return R_MORE;
        end
        if (phase == 1) begin
          segs_left = low_byte | (b << 8);
          if (cur_cmd == CMD_PIX_SET) begin
            if (segs_left * 3 > bytes_left) return R_TRUNC;
            if (segs_left == 0) return R_DONE;
            phase = 2;
            return R_MORE;
          end
          return seg_start(cur_cmd == CMD_RUN_FILL ? 4 : 3);
        end
        if (phase == 3) begin
          wr_pos = low_byte | (b << 8);
          phase = 4;
          return R_MORE;
        end
        if (cur_cmd == CMD_PIX_SET) begin
          if (wr_pos < FB) frm_mem[wr_pos] = b[7:0];
          segs_left = (segs_left - 1) & 16'hFFFF;
          if (segs_left == 0) return R_DONE;
          phase = 2;
          return R_MORE;
        end
        if (cur_cmd == CMD_RUN_FILL) begin
          if (phase == 4) begin
            seg_len = b;
            phase = 5;
            return R_MORE;
          end
          if (wr_pos + seg_len <= FB)
            for (int unsigned i = 0; i < seg_len; i++) frm_mem[wr_pos + i] = b[7:0];
          return seg_end(4);
        end
        if (phase == 4) begin
          seg_len = b;
          if (bytes_left < seg_len) return R_TRUNC;
          if (seg_len == 0) return seg_end(3);
          phase = (wr_pos + seg_len <= FB) ? 5 : 6;
          return R_MORE;
        end
        if (phase == 5 && wr_pos < FB) frm_mem[wr_pos] = b[7:0];
        wr_pos++;
        seg_len--;
        return (seg_len == 0) ? seg_end(3) : R_MORE;
      end
    endcase
  endfunction

  function automatic int unsigned start_cmd(int unsigned c);
    cur_cmd = c;
    phase = 0;
    wr_pos = 0;
    seg_len = 0;
    segs_left = 0;
    low_byte = 0;
    if (c == CMD_PAL_COPY && bytes_left < PB) return R_TRUNC;
    if (c == CMD_FRM_COPY && bytes_left < FB) return R_TRUNC;
    if (c == CMD_PAL_SEG && bytes_left < 1) return R_TRUNC;
    if (c >= CMD_PIX_SET && bytes_left < 2) return R_TRUNC;
    return R_MORE;
  endfunction

  function automatic logic [2:0] decode_byte(int unsigned b);
    int unsigned r;
    if (!open) return ST_IGNORED;
    bytes_left = (bytes_left - 1) & 16'hFFFF;
    if (phase == PH_IDLE) begin
      if (b >= NUM_COMMANDS) begin
        open = 0;
        return ST_UNKNOWN;
      end
      r = start_cmd(b);
    end else begin
      r = take_byte(b);
    end
    if (r == R_TRUNC) begin
      open = 0;
      return ST_TRUNC;
    end
    if (r == R_DONE) begin
      cmds_left = (cmds_left - 1) & 16'hFFFF;
      phase = PH_IDLE;
      if (cmds_left == 0) begin
        open = 0;
        return ST_DONE;
      end
    end
    if (bytes_left == 0) begin
      open = 0;
      if (phase != PH_IDLE && (cur_cmd == CMD_PAL_RLE || cur_cmd == CMD_FRM_RLE)) begin
        phase = PH_IDLE;
        cmds_left = (cmds_left - 1) & 16'hFFFF;
        if (cmds_left == 0) return ST_DONE;
      end
      return ST_TRUNC;
    end
    return ST_OK;
  endfunction

  function automatic reply_t decode_word(word_t w);
    reply_t r;
    r = '0;
    case (w.action)
      ACT_BEGIN: begin
        cmds_left = w.cmd_cnt;
        bytes_left = w.byte_cnt;
        phase = PH_IDLE;
        open = (cmds_left != 0 && bytes_left != 0);
        r.status = open ? ST_OK : ST_DONE;
      end
      ACT_DATA: r.status = decode_byte(w.byte_val);
      ACT_RDF: begin
        if (w.addr < FB) r.value = frm_mem[w.addr];
        else r.status = ST_BADADDR;
      end
      default: begin
        if (w.addr < PB) r.value = pal_mem[w.addr];
        else r.status = ST_BADADDR;
      end
    endcase
    return r;
  endfunction

  task automatic send_word(word_t w, bit typed, reply_t typed_reply);
    reply_t r;
    s_axis_tdata <= {w.addr, w.byte_cnt, w.cmd_cnt, w.byte_val};
    s_axis_tuser <= w.action;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = decode_word(w);
    reply_q.push_back(typed ? typed_reply : r);
    words_sent++;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  function automatic word_t mk(logic [1:0] a, logic [7:0] b, logic [15:0] cc,
                               logic [15:0] bc, logic [15:0] ad);
    word_t w;
    w.action = a;
    w.byte_val = b;
    w.cmd_cnt = cc;
    w.byte_cnt = bc;
    w.addr = ad;
    return w;
  endfunction

  task automatic row(logic [1:0] a, logic [7:0] b, logic [15:0] cc, logic [15:0] bc,
                     logic [15:0] ad, logic [7:0] v, logic [2:0] st);
    dir_words.push_back(mk(a, b, cc, bc, ad));
    dir_replies.push_back({v, st});
  endtask

  task automatic rand_word();
    word_t w;
    w = mk(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
           16'($urandom_range(0, 65535)));
    if (w.action == ACT_DATA && w.byte_val == CMD_FRM_FILL) w.byte_val = 8'hF4;
    send_word(w, 0, '0);
  endtask

  task automatic send_frame();
    logic [7:0] bq[$];
    int ncmd;
    int cnt;
    int n;
    int unsigned len;
    int unsigned c;
    word_t w;
    ncmd = $urandom_range(1, 4);
    for (int k = 0; k < ncmd; k++) begin
      c = $urandom_range(0, 9);
      if (c == CMD_FRM_FILL && fills_left == 0) c = CMD_PIX_SET;
      if (c == CMD_PAL_COPY && $urandom_range(0, 15) != 0) c = CMD_PAL_SEG;
      if ($urandom_range(0, 40) == 0) c = $urandom_range(NUM_COMMANDS, 255);
      bq.push_back(8'(c));
      case (c)
        CMD_PAL_FILL: bq.push_back(8'($urandom_range(0, 255)));
        CMD_FRM_FILL: begin
          fills_left--;
          bq.push_back(8'($urandom_range(0, 255)));
        end
        CMD_PAL_COPY: repeat (PB) bq.push_back(8'($urandom_range(0, 255)));
        CMD_FRM_COPY: repeat ($urandom_range(0, 4)) bq.push_back(8'($urandom_range(0, 255)));
        CMD_PAL_RLE, CMD_FRM_RLE: begin
          len = 0;
          while (len < ((c == CMD_PAL_RLE && $urandom_range(0, 3) != 0) ? PB : 40)) begin
            if ($urandom_range(0, 2) != 0) begin
              n = $urandom_range(0, 63);
              bq.push_back(RUN_MARK | 8'(n));
              bq.push_back(8'($urandom_range(0, 255)));
              len += n;
            end else begin
              bq.push_back(8'($urandom_range(0, 8'hBF)));
              len++;
            end
          end
        end
        CMD_PAL_SEG: begin
          cnt = $urandom_range(0, 3);
          bq.push_back(8'(cnt));
          repeat (cnt) begin
            bq.push_back(8'($urandom_range(0, 3) == 0 ? $urandom_range(250, 255)
                                                      : $urandom_range(0, 255)));
            n = $urandom_range(0, 4);
            bq.push_back(8'(n));
            repeat (3 * n) bq.push_back(8'($urandom_range(0, 255)));
          end
        end
        default: begin
          cnt = $urandom_range(0, 4);
          bq.push_back(cnt[7:0]);
          bq.push_back(8'h00);
          repeat (cnt) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(63900, 65535)
                                              : $urandom_range(0, 1023);
            bq.push_back(len[7:0]);
            bq.push_back(len[15:8]);
            if (c == CMD_RUN_FILL) begin
              bq.push_back(8'($urandom_range(0, 255)));
              bq.push_back(8'($urandom_range(0, 255)));
            end else if (c == CMD_FRM_SEG) begin
              n = $urandom_range(0, 6);
              bq.push_back(8'(n));
              repeat (n) bq.push_back(8'($urandom_range(0, 255)));
            end else begin
              bq.push_back(8'($urandom_range(0, 255)));
            end
          end
        end
      endcase
    end
    len = bq.size();
    case ($urandom_range(0, 9))
      0: len = len - $urandom_range(1, 3);
      1: len = len + $urandom_range(1, 5);
      default: ;
    endcase
    send_word(mk(ACT_BEGIN, '0, 16'(($urandom_range(0, 9) == 0) ? ncmd + 1 : ncmd),
                 16'(len), '0), 0, '0);
    frames++;
    for (int i = 0; i < bq.size() + $urandom_range(0, 2); i++) begin
      if ($urandom_range(0, 9) == 0) begin
        w = mk($urandom_range(0, 1) ? ACT_RDF : ACT_RDP, '0, '0, '0,
               16'($urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 1023)));
        send_word(w, 0, '0);
      end
      send_word(mk(ACT_DATA, (i < bq.size()) ? bq[i] : 8'($urandom_range(0, 255)),
                   '0, '0, '0), 0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results++;
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: value %0h status %0d",
                                   m_axis_tdata, m_axis_tuser);
      end else begin
        automatic reply_t e = reply_q.pop_front();
        if (e.value !== m_axis_tdata || e.status !== m_axis_tuser) begin
          errors++;
          if (errors <= 10)
            $display("word %0d: expected value %0h status %0d, got value %0h status %0d",
                     results, e.value, e.status, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      if (long_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_req = 0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #60000000;
    $display("animation_frame_command_decoder_top: mismatch");
    $finish;
  end

  initial begin
    for (int i = 0; i < FB; i++) frm_mem[i] = '0;
    for (int i = 0; i < PB; i++) pal_mem[i] = '0;
    cmds_left = 0; bytes_left = 0; segs_left = 0; wr_pos = 0;
    seg_len = 0; low_byte = 0; cur_cmd = 0; phase = 0; open = 0;

    row(ACT_RDF,   0,  0,  0,  0,     0, ST_OK);
    row(ACT_RDP,   0,  0,  0,  767,   0, ST_OK);
    row(ACT_RDF,   0,  0,  0,  64000, 0, ST_BADADDR);
    row(ACT_RDP,   0,  0,  0,  768,   0, ST_BADADDR);
    row(ACT_RDF,   0,  0,  0,  16'hFFFF, 0, ST_BADADDR);
    row(ACT_DATA,  8'h55, 0, 0, 0,    0, ST_IGNORED);
    row(ACT_BEGIN, 0,  0,  5,  0,     0, ST_DONE);
    row(ACT_BEGIN, 0,  1,  0,  0,     0, ST_DONE);
    row(ACT_BEGIN, 0,  2,  2,  0,     0, ST_OK);
    row(ACT_DATA,  CMD_PAL_FILL, 0, 0, 0, 0, ST_OK);
    row(ACT_DATA,  8'hAB, 0, 0, 0,    0, ST_TRUNC);
    row(ACT_BEGIN, 0,  1,  1,  0,     0, ST_OK);
    row(ACT_DATA,  8'h0A, 0, 0, 0,    0, ST_UNKNOWN);
    row(ACT_RDP,   0,  0,  0,  5,     8'hAB, ST_OK);
    row(ACT_BEGIN, 0,  1,  3,  0,     0, ST_OK);
    row(ACT_DATA,  CMD_FRM_COPY, 0, 0, 0, 0, ST_TRUNC);
    row(ACT_BEGIN, 0,  1,  2,  0,     0, ST_OK);
    row(ACT_DATA,  CMD_FRM_FILL, 0, 0, 0, 0, ST_OK);
    row(ACT_DATA,  8'hFF, 0, 0, 0,    0, ST_DONE);
    row(ACT_RDF,   0,  0,  0,  63999, 8'hFF, ST_OK);
    row(ACT_DATA,  8'h01, 0, 0, 0,    0, ST_IGNORED);
    row(ACT_BEGIN, 0,  16'hFFFF, 16'hFFFF, 0, 0, ST_OK);
    row(ACT_DATA,  CMD_FRM_SEG, 0, 0, 0, 0, ST_OK);
    row(ACT_BEGIN, 0,  1,  1,  0,     0, ST_OK);
    row(ACT_DATA,  CMD_PAL_FILL, 0, 0, 0, 0, ST_TRUNC);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_words[i]) send_word(dir_words[i], 1, dir_replies[i]);

    while (words_sent < 1600) begin
      if (words_sent > 600 && !long_done) begin
        long_req = 1;
        long_done = 1;
      end
      if (words_sent > 1000 && !paused) begin
        paused = 1;
        s_axis_tvalid <= 1'b0;
        wait (reply_q.size() == 0);
        @(posedge clk_i);
      end
      if (words_sent > 1500) no_idle = 1;
      if ($urandom_range(0, 6) == 0) rand_word();
      else send_frame();
    end
    s_axis_tvalid <= 1'b0;
    wait (reply_q.size() == 0);
    repeat (300) @(posedge clk_i);

    $display("covered %0d words in %0d random frames, %0d results checked",
             words_sent, frames, results);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("animation_frame_command_decoder_top: match");
    end else begin
      $display("%0d mismatches", errors);
      $display("animation_frame_command_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
design/afcd_pkg.sv
design/afcd_ctrl.sv
design/afcd_dp.sv
design/animation_frame_command_decoder_top.sv
dv/animation_frame_command_decoder_top_tb.sv
